// ===== hw/rtl/bnms_pkg.sv =====
// shared types and constants for the box suppression block
`timescale 1ns / 1ps

package bnms_pkg;

    localparam int unsigned COORD_W = 16;
    localparam int unsigned SCORE_W = 16;
    localparam int unsigned INDEX_W = 6;
    localparam int unsigned RESULT_LIMIT = 64;
    localparam logic [15:0] THRESH_RESET = 16'd26214;

    typedef struct packed {
        logic signed [15:0] l;
        logic signed [15:0] t;
        logic signed [15:0] r;
        logic signed [15:0] b;
        logic        [15:0] s;
    } box_t;

    // control from the sequencer to every cell
    typedef struct packed {
        logic clear;
        logic load;
        logic shift;
        logic cmp;
    } cell_ctl_t;

    typedef enum logic [4:0] {
        ST_LOAD  = 5'b00001,
        ST_PICK  = 5'b00010,
        ST_AREA  = 5'b00100,
        ST_CMP   = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

endpackage

// ===== hw/rtl/box_non_max_suppression.sv =====
// top level: load sorted chain, pop head, suppress overlaps across the chain
// the first kept word is registered in EMIT after PICK, AREA and CMP follow a set's last word
// throughput: one box word per cycle while loading; then each stored box passes through PICK,
// AREA, CMP and EMIT, held on output stalls, and a final PICK runs before loading resumes
// the suppression test runs in every cell in parallel over a 3 stage pipe
// reset clears the chain, counters, flags and the threshold to 26214
`timescale 1ns / 1ps

module box_non_max_suppression #(
    parameter int unsigned MAX_BOXES = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [15:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [15:0]  left_x,
    input  logic signed [15:0]  top_y,
    input  logic signed [15:0]  right_x,
    input  logic signed [15:0]  bottom_y,
    input  logic [15:0]         confidence,
    input  logic                last_box,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [15:0]  kept_left,
    output logic signed [15:0]  kept_top,
    output logic signed [15:0]  kept_right,
    output logic signed [15:0]  kept_bottom,
    output logic [15:0]         kept_score,
    output logic [5:0]          source_index,
    output logic                last_kept,
    output logic                overflowed
);
    import bnms_pkg::*;

    localparam int unsigned CW = $clog2(MAX_BOXES + 1);

    state_t             state_reg, state_next;
    logic [15:0]        thresh_reg;
    logic [CW-1:0]      count_reg;
    logic [15:0]        arr_reg;
    logic               ovf_reg;
    logic [1:0]         cnt_reg;
    logic [6:0]         kept_reg;
    logic               have_reg;
    box_t               pick_reg;
    logic [5:0]         pidx_reg;
    logic signed [32:0] parea_reg;
    box_t               obox_reg;
    logic [5:0]         oidx_reg;
    logic               olast_reg, oovf_reg, ovalid_reg;
    cell_ctl_t          ctl;
    box_t               new_box, head_box;
    logic [15:0]        head_idx;
    logic               head_occ, head_live, any_live, accept, more;

    assign new_box = '{l: left_x, t: top_y, r: right_x, b: bottom_y, s: confidence};
    assign accept  = in_valid && in_ready;
    assign in_ready  = (state_reg == ST_LOAD);
    assign cfg_ready = 1'b1;

    // further kept box exists after the current pick
    assign more = any_live;

    always_comb
    begin
        ctl = '0;
        ctl.load  = accept && (32'(count_reg) < MAX_BOXES);
        ctl.shift = (state_reg == ST_PICK) && !(ovalid_reg && !out_ready);
        ctl.cmp   = (state_reg == ST_AREA) && have_reg;
        ctl.clear = (state_reg == ST_PICK) && !head_occ && !have_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: if (accept && last_box) state_next = ST_PICK;
            ST_PICK:
                if (!head_occ && !have_reg)
                    state_next = ST_LOAD;
                else if (ctl.shift)
                    state_next = ST_AREA;
            ST_AREA: state_next = ST_CMP;
            ST_CMP:  if (cnt_reg == 2'd2) state_next = ST_EMIT;
            ST_EMIT: if (!ovalid_reg || out_ready) state_next = ST_PICK;
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_LOAD;
            thresh_reg <= THRESH_RESET;
            count_reg  <= '0;
            arr_reg    <= '0;
            ovf_reg    <= 1'b0;
            cnt_reg    <= '0;
            kept_reg   <= '0;
            have_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                thresh_reg <= cfg_data;
            if (accept)
            begin
                arr_reg <= arr_reg + 16'd1;
                if (ctl.load)
                    count_reg <= count_reg + 1'b1;
                else
                    ovf_reg <= 1'b1;
            end
            cnt_reg <= (state_reg == ST_CMP) ? cnt_reg + 2'd1 : 2'd0;
            if (state_reg == ST_PICK && ctl.shift)
                have_reg <= head_occ && head_live;
            if (state_reg == ST_EMIT && (!ovalid_reg || out_ready))
            begin
                if (have_reg && kept_reg < 7'(RESULT_LIMIT))
                begin
                    ovalid_reg <= 1'b1;
                    kept_reg   <= kept_reg + 7'd1;
                end
                else
                    ovalid_reg <= 1'b0;
                have_reg <= 1'b0;
            end
            else if (ovalid_reg && out_ready)
                ovalid_reg <= 1'b0;
            if (ctl.clear)
            begin
                count_reg <= '0;
                arr_reg   <= '0;
                ovf_reg   <= 1'b0;
                kept_reg  <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_PICK && ctl.shift)
        begin
            pick_reg <= head_box;
            pidx_reg <= head_idx[5:0];
        end
        if (state_reg == ST_AREA)
            parea_reg <= (17'(pick_reg.r) - 17'(pick_reg.l))
                       * (17'(pick_reg.b) - 17'(pick_reg.t));
        if (state_reg == ST_EMIT && (!ovalid_reg || out_ready))
        begin
            obox_reg  <= pick_reg;
            oidx_reg  <= pidx_reg;
            oovf_reg  <= ovf_reg;
            // last when nothing kept remains or the result limit is hit
            olast_reg <= !more || (kept_reg == 7'(RESULT_LIMIT - 1));
        end
    end

    bnms_chain #(.DEPTH(MAX_BOXES)) u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .new_box   (new_box),
        .new_idx   (arr_reg),
        .pick_box  (pick_reg),
        .pick_area (parea_reg),
        .thresh    (thresh_reg),
        .head_box  (head_box),
        .head_idx  (head_idx),
        .head_occ  (head_occ),
        .head_live (head_live),
        .any_live  (any_live)
    );

    assign out_valid    = ovalid_reg;
    assign kept_left    = obox_reg.l;
    assign kept_top     = obox_reg.t;
    assign kept_right   = obox_reg.r;
    assign kept_bottom  = obox_reg.b;
    assign kept_score   = obox_reg.s;
    assign source_index = oidx_reg;
    assign last_kept    = olast_reg;
    assign overflowed   = oovf_reg;

`ifndef SYNTH
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state not one-hot");
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= MAX_BOXES)
        else $error("count above capacity");
    a_kept_cap: assert property (@(posedge clk) disable iff (!rst_n)
        kept_reg <= 7'(RESULT_LIMIT))
        else $error("too many results");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg && !out_ready |=> ovalid_reg && $stable(oidx_reg))
        else $error("result dropped");
`endif

endmodule

// ===== hw/rtl/bnms_cell.sv =====
// one sorted slot: holds a box, keeps order on insert, tests overlap against the current pick
`timescale 1ns / 1ps

module bnms_cell
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  bnms_pkg::cell_ctl_t  ctl,
    input  bnms_pkg::box_t       new_box,
    input  logic [15:0]          new_idx,
    input  logic                 ins_here,
    input  bnms_pkg::box_t       prev_box,
    input  logic [15:0]          prev_idx,
    input  logic                 prev_occ,
    input  logic                 prev_ins,
    input  bnms_pkg::box_t       next_box,
    input  logic [15:0]          next_idx,
    input  logic                 next_occ,
    input  logic                 next_live,
    input  bnms_pkg::box_t       pick_box,
    input  logic signed [32:0]   pick_area,
    input  logic [15:0]          thresh,
    output bnms_pkg::box_t       box,
    output logic [15:0]          idx,
    output logic                 occ,
    output logic                 live,
    output logic                 ins_below
);
    import bnms_pkg::*;

    box_t               box_reg;
    logic [15:0]        idx_reg;
    logic               occ_reg, occ_next;
    logic               live_reg, live_next;
    logic signed [16:0] w_reg, h_reg, aw_reg, ah_reg;
    logic               st1_reg, st2_reg;
    logic signed [33:0] inter_reg, area_reg;
    logic signed [16:0] x1, y1, x2, y2, w, h;
    logic signed [35:0] uni;
    logic signed [53:0] lhs, rhs;
    logic               sup;

    // this slot is empty or holds a lower score; the chain takes the first such slot as the insert point
    assign ins_below = occ_reg ? (box_reg.s < new_box.s) : 1'b1;

    always_comb
    begin
        x1 = (box_reg.l > pick_box.l) ? 17'(box_reg.l) : 17'(pick_box.l);
        y1 = (box_reg.t > pick_box.t) ? 17'(box_reg.t) : 17'(pick_box.t);
        x2 = (box_reg.r < pick_box.r) ? 17'(box_reg.r) : 17'(pick_box.r);
        y2 = (box_reg.b < pick_box.b) ? 17'(box_reg.b) : 17'(pick_box.b);
        w  = (x2 - x1 > 0) ? x2 - x1 : 17'sd0;
        h  = (y2 - y1 > 0) ? y2 - y1 : 17'sd0;
        uni = 36'(area_reg) + 36'(pick_area) - 36'(inter_reg);
        lhs = 54'(inter_reg) <<< 16;
        rhs = $signed({1'b0, thresh}) * uni;
        if (uni > 0)
            sup = lhs > rhs;
        else if (uni == 0)
            sup = inter_reg > 0;
        else
            sup = 1'b0;
    end

    always_comb
    begin
        occ_next  = occ_reg;
        live_next = live_reg;
        if (ctl.clear)
        begin
            occ_next  = 1'b0;
            live_next = 1'b0;
        end
        else if (ctl.load && (ins_here || (prev_ins && prev_occ)))
        begin
            occ_next  = 1'b1;
            live_next = 1'b1;
        end
        else if (ctl.shift)
        begin
            occ_next  = next_occ;
            live_next = next_live;
        end
        else if (st2_reg && sup)
            live_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg  <= 1'b0;
            live_reg <= 1'b0;
            st1_reg  <= 1'b0;
            st2_reg  <= 1'b0;
        end
        else
        begin
            occ_reg  <= occ_next;
            live_reg <= live_next;
            st1_reg  <= ctl.cmp && live_reg;
            st2_reg  <= st1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load && prev_ins && prev_occ)
        begin
            box_reg <= prev_box;
            idx_reg <= prev_idx;
        end
        else if (ctl.load && ins_here)
        begin
            box_reg <= new_box;
            idx_reg <= new_idx;
        end
        else if (ctl.shift)
        begin
            box_reg <= next_box;
            idx_reg <= next_idx;
        end
        w_reg  <= w;
        h_reg  <= h;
        aw_reg <= 17'(box_reg.r) - 17'(box_reg.l);
        ah_reg <= 17'(box_reg.b) - 17'(box_reg.t);
        inter_reg <= w_reg * h_reg;
        area_reg  <= aw_reg * ah_reg;
    end

    assign box  = box_reg;
    assign idx  = idx_reg;
    assign occ  = occ_reg;
    assign live = live_reg;

endmodule

// ===== hw/rtl/bnms_chain.sv =====
// row of cells forming a sorted shift chain
`timescale 1ns / 1ps

module bnms_chain #(
    parameter int unsigned DEPTH = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  bnms_pkg::cell_ctl_t  ctl,
    input  bnms_pkg::box_t       new_box,
    input  logic [15:0]          new_idx,
    input  bnms_pkg::box_t       pick_box,
    input  logic signed [32:0]   pick_area,
    input  logic [15:0]          thresh,
    output bnms_pkg::box_t       head_box,
    output logic [15:0]          head_idx,
    output logic                 head_occ,
    output logic                 head_live,
    output logic                 any_live
);
    import bnms_pkg::*;

    box_t             box_w  [DEPTH+2];
    logic [15:0]      idx_w  [DEPTH+2];
    logic             occ_w  [DEPTH+2];
    logic             live_w [DEPTH+2];
    logic             insb_w [DEPTH+1];
    logic             hit_w  [DEPTH];
    logic [DEPTH-1:0] live_v;

    // slot g sits at position g+1, both ends are fed by an empty slot
    assign box_w[0]        = '0;
    assign idx_w[0]        = '0;
    assign occ_w[0]        = 1'b0;
    assign live_w[0]       = 1'b0;
    assign box_w[DEPTH+1]  = '0;
    assign idx_w[DEPTH+1]  = '0;
    assign occ_w[DEPTH+1]  = 1'b0;
    assign live_w[DEPTH+1] = 1'b0;
    assign insb_w[0]       = 1'b0;

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        // first slot that is empty or where the new box ranks strictly higher
        assign hit_w[g]  = insb_w[g+1] && !insb_w[g];
        assign live_v[g] = live_w[g+1];
        bnms_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .new_box   (new_box),
            .new_idx   (new_idx),
            .ins_here  (hit_w[g]),
            .prev_box  (box_w[g]),
            .prev_idx  (idx_w[g]),
            .prev_occ  (occ_w[g]),
            .prev_ins  (insb_w[g]),
            .next_box  (box_w[g+2]),
            .next_idx  (idx_w[g+2]),
            .next_occ  (occ_w[g+2]),
            .next_live (live_w[g+2]),
            .pick_box  (pick_box),
            .pick_area (pick_area),
            .thresh    (thresh),
            .box       (box_w[g+1]),
            .idx       (idx_w[g+1]),
            .occ       (occ_w[g+1]),
            .live      (live_w[g+1]),
            .ins_below (insb_w[g+1])
        );
    end

    assign head_box  = box_w[1];
    assign head_idx  = idx_w[1];
    assign head_occ  = occ_w[1];
    assign head_live = live_w[1];
    assign any_live  = |live_v;

endmodule

// ===== tb/tb_box_non_max_suppression.sv =====
// testbench for the box suppression block: directed and random box sets checked against a greedy overlap predictor
`timescale 1ns / 1ps

module tb_box_non_max_suppression;
    import bnms_pkg::*;

    localparam int CAPACITY = 64;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        box_t b;
        logic last;
    } box_word_t;

    typedef struct {
        box_t        b;
        logic [5:0]  idx;
        logic        lk;
        logic        ov;
    } kept_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [15:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [15:0] left_x = '0, top_y = '0, right_x = '0, bottom_y = '0;
    logic [15:0] confidence = '0;
    logic last_box = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [15:0] kept_left, kept_top, kept_right, kept_bottom;
    logic [15:0] kept_score;
    logic [5:0] source_index;
    logic last_kept, overflowed;

    box_word_t  pending_boxes[$];
    kept_word_t kept_expected[$];
    box_t       open_set[$];
    logic       open_dropped = 1'b0;
    logic [15:0] thresh = THRESH_RESET;
    int mismatches = 0;
    int cycles = 0;
    int hold_left = 0;
    bit quiet = 1'b0;

    always #4 clk = ~clk;

    box_non_max_suppression #(.MAX_BOXES(CAPACITY)) u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .left_x(left_x), .top_y(top_y), .right_x(right_x), .bottom_y(bottom_y),
        .confidence(confidence), .last_box(last_box),
        .out_valid(out_valid), .out_ready(out_ready),
        .kept_left(kept_left), .kept_top(kept_top), .kept_right(kept_right),
        .kept_bottom(kept_bottom), .kept_score(kept_score),
        .source_index(source_index), .last_kept(last_kept), .overflowed(overflowed)
    );

    function automatic longint box_area(box_t x);
        return (longint'(x.r) - longint'(x.l)) * (longint'(x.b) - longint'(x.t));
    endfunction

    function automatic bit overlap_suppresses(box_t a, box_t c);
        longint x1, y1, x2, y2, w, h, inter, uni;
        x1 = (a.l > c.l) ? a.l : c.l;
        y1 = (a.t > c.t) ? a.t : c.t;
        x2 = (a.r < c.r) ? a.r : c.r;
        y2 = (a.b < c.b) ? a.b : c.b;
        w = (x2 - x1 > 0) ? x2 - x1 : 0;
        h = (y2 - y1 > 0) ? y2 - y1 : 0;
        inter = w * h;
        uni = box_area(a) + box_area(c) - inter;
        if (uni > 0)
            return inter * 65536 > longint'(thresh) * uni;
        if (uni == 0)
            return inter > 0;
        return 1'b0;
    endfunction

    // greedy suppression over the closed set, results in score order
    task automatic suppress_set();
        int order[$];
        bit gone[];
        int n, j, cnt;
        kept_word_t k;
        n = open_set.size();
        gone = new[n];
        for (int i = 0; i < n; i++)
        begin
            j = order.size();
            while (j > 0 && open_set[order[j-1]].s < open_set[i].s)
                j--;
            order.insert(j, i);
        end
        cnt = 0;
        for (int i = 0; i < n; i++)
        begin
            if (gone[i])
                continue;
            if (cnt < RESULT_LIMIT)
            begin
                k.b = open_set[order[i]];
                k.idx = order[i][5:0];
                k.lk = 1'b0;
                k.ov = open_dropped;
                kept_expected.insert(kept_expected.size(), k);
                cnt++;
            end
            for (int m = i + 1; m < n; m++)
                if (!gone[m] && overlap_suppresses(open_set[order[i]], open_set[order[m]]))
                    gone[m] = 1'b1;
        end
        if (cnt > 0)
            kept_expected[kept_expected.size()-1].lk = 1'b1;
        open_set.delete();
        open_dropped = 1'b0;
    endtask

    task automatic take_box(box_word_t w);
        if (open_set.size() < CAPACITY)
            open_set.insert(open_set.size(), w.b);
        else
            open_dropped = 1'b1;
        if (w.last)
            suppress_set();
    endtask

    function automatic box_word_t make_box(int mode, logic last);
        box_word_t w;
        int cx, cy;
        if (mode == 0)
        begin
            w.b.l = 16'($urandom); w.b.t = 16'($urandom);
            w.b.r = 16'($urandom); w.b.b = 16'($urandom);
            w.b.s = 16'($urandom);
        end
        else
        begin
            // clustered boxes so that overlaps are common
            cx = $urandom_range(400, 0) - 200;
            cy = $urandom_range(400, 0) - 200;
            w.b.l = 16'(cx - $urandom_range(120, 0));
            w.b.t = 16'(cy - $urandom_range(120, 0));
            w.b.r = 16'(cx + $urandom_range(120, 0));
            w.b.b = 16'(cy + $urandom_range(120, 0));
            if (mode == 2)
                w.b.s = 16'($urandom_range(4, 0) * 16384);
            else
                w.b.s = 16'($urandom);
            if ($urandom_range(19, 0) == 0)
                w.b.r = 16'(w.b.l - $urandom_range(50, 0));
        end
        w.last = last;
        return w;
    endfunction

    task automatic add_set(int count, int mode);
        for (int i = 0; i < count; i++)
            pending_boxes.insert(pending_boxes.size(), make_box(mode, i == count - 1));
    endtask

    task automatic add_fixed(int l, int t, int r, int b, int s, logic last);
        box_word_t w;
        w.b.l = 16'(l); w.b.t = 16'(t); w.b.r = 16'(r); w.b.b = 16'(b); w.b.s = 16'(s);
        w.last = last;
        pending_boxes.insert(pending_boxes.size(), w);
    endtask

    task automatic drain();
        while (pending_boxes.size() != 0 || in_valid || kept_expected.size() != 0)
            @(negedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_thresh(logic [15:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        thresh = v;
        cfg_valid <= 1'b0;
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
                take_box('{b: '{left_x, top_y, right_x, bottom_y, confidence},
                           last: last_box});
            if (!in_valid || in_ready)
            begin
                if (pending_boxes.size() != 0 && (quiet || $urandom_range(99, 0) >= 26))
                begin
                    box_word_t w;
                    w = pending_boxes.pop_front();
                    in_valid <= 1'b1;
                    left_x <= w.b.l; top_y <= w.b.t; right_x <= w.b.r; bottom_y <= w.b.b;
                    confidence <= w.b.s; last_box <= w.last;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off and cycle limit watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == 600)
            hold_left <= 800;
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (kept_expected.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word: idx %0d score %0d", source_index, kept_score);
                end
                else
                begin
                    kept_word_t e;
                    e = kept_expected.pop_front();
                    if (kept_left !== e.b.l || kept_top !== e.b.t || kept_right !== e.b.r
                        || kept_bottom !== e.b.b || kept_score !== e.b.s
                        || source_index !== e.idx || last_kept !== e.lk || overflowed !== e.ov)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch exp %0d %0d %0d %0d s%0d i%0d l%0d o%0d",
                                      " got %0d %0d %0d %0d s%0d i%0d l%0d o%0d"},
                                e.b.l, e.b.t, e.b.r, e.b.b, e.b.s, e.idx, e.lk, e.ov,
                                kept_left, kept_top, kept_right, kept_bottom, kept_score,
                                source_index, last_kept, overflowed);
                    end
                end
            end
            out_ready <= (hold_left == 0) && (quiet || $urandom_range(99, 0) >= 26);
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: reset threshold, extremes, ties, degenerate and inverted boxes
        add_fixed(-32768, -32768, 32767, 32767, 65535, 1'b0);
        add_fixed(-32768, -32768, 32767, 32767, 0, 1'b0);
        add_fixed(0, 0, 100, 100, 30000, 1'b0);
        add_fixed(10, 10, 110, 110, 30000, 1'b0);
        add_fixed(50, 50, 50, 50, 30000, 1'b0);
        add_fixed(50, 50, 50, 50, 30000, 1'b0);
        add_fixed(100, 100, 0, 0, 40000, 1'b0);
        add_fixed(0, 0, 100, 0, 1, 1'b1);
        add_fixed(5, 5, 6, 6, 7, 1'b1);
        add_fixed(32767, -32768, -32768, 32767, 65535, 1'b0);
        add_fixed(-100, -100, 100, 100, 20000, 1'b1);
        drain();

        write_thresh(16'd0);
        add_set(6, 1);
        add_set(5, 2);
        drain();

        write_thresh(16'hFFFF);
        add_set(6, 1);
        add_set(4, 0);
        drain();

        // overflow: the first set drops a box and its last word, the second drops only its last word
        write_thresh(16'd32768);
        add_set(CAPACITY + 2, 1);
        add_set(CAPACITY + 1, 2);
        drain();

        write_thresh(THRESH_RESET);
        for (int s = 0; s < 18; s++)
            add_set($urandom_range(8, 1), $urandom_range(9, 0) == 0 ? 0 : $urandom_range(2, 1));
        drain();

        quiet = 1'b1;
        write_thresh(16'($urandom));
        for (int s = 0; s < 12; s++)
            add_set($urandom_range(8, 1), $urandom_range(2, 0));
        drain();
        quiet = 1'b0;

        write_thresh(16'($urandom_range(40000, 10000)));
        for (int s = 0; s < 10; s++)
            add_set($urandom_range(10, 1), $urandom_range(2, 1));
        drain();

        repeat (100) @(posedge clk);
        if (mismatches == 0 && kept_expected.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
